[rtl/core/rawc_pkg.sv]
package rawc_pkg;

	localparam int REG_COUNT = 16;
	localparam int WORD_BITS = 32;
	localparam int REG_IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int CNT_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

	localparam int OPND_W = 32;
	localparam int DEST_W = 8;
	localparam int MODE_W = 3;
	localparam int BAD_W  = 2;

	localparam logic [MODE_W-1:0] MODE_SUB = 3'd0;
	localparam logic [MODE_W-1:0] MODE_MUL = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DIV = 3'd2;
	localparam logic [MODE_W-1:0] MODE_MOD = 3'd3;
	localparam logic [MODE_W-1:0] MODE_AND = 3'd4;

	localparam logic [BAD_W-1:0] BAD_NONE = 2'd0;
	localparam logic [BAD_W-1:0] BAD_REG  = 2'd1;
	localparam logic [BAD_W-1:0] BAD_DIV0 = 2'd2;

	typedef struct packed {
		logic load;
		logic rd_b;
		logic cap_x;
		logic cap_y;
		logic start;
		logic step;
		logic finish;
	} rawc_cmd_t;

	typedef struct packed {
		logic mode_ok;
		logic ops_ok;
		logic need_iter;
		logic iter_last;
		logic out_free;
	} rawc_sts_t;

endpackage

[rtl/core/rawc_ram.sv]
module rawc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/rawc_datapath.sv]
module rawc_datapath
	import rawc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  rawc_cmd_t         cmd,
	output rawc_sts_t         sts,
	input  logic [MODE_W-1:0] in_mode,
	input  logic              in_first_is_value,
	input  logic [OPND_W-1:0] in_first_operand,
	input  logic              in_second_is_value,
	input  logic [OPND_W-1:0] in_second_operand,
	input  logic [DEST_W-1:0] in_dest_register,
	input  logic              out_ready,
	output logic              out_valid,
	output logic              out_written,
	output logic [OPND_W-1:0] out_result_value,
	output logic              out_carry_flag,
	output logic [BAD_W-1:0]  out_bad_operand
);

	logic [MODE_W-1:0]    mode_q;
	logic                 fv_q;
	logic                 sv_q;
	logic [OPND_W-1:0]    a_q;
	logic [OPND_W-1:0]    b_q;
	logic [DEST_W-1:0]    d_q;
	logic [WORD_BITS-1:0] x_q;
	logic [WORD_BITS-1:0] y_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] sh_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 carry_q;
	logic [REG_COUNT-1:0] vld_q;
	logic                 rd_vld_q;
	logic                 out_vld_q;

	logic                 a_ok, b_ok, d_ok;
	logic                 is_and, is_divmod;
	logic                 y_zero, div0;
	logic [REG_IDX_W-1:0] a_idx, b_idx, d_idx, rd_addr;
	logic [WORD_BITS-1:0] ram_rdata, rd_word;
	logic [WORD_BITS:0]   rem_sh, diff;
	logic [WORD_BITS-1:0] r;
	logic                 wr_ok, carry_nx;
	logic [BAD_W-1:0]     bad_nx;

	assign a_ok = (a_q >= 32'd1) && (a_q <= 32'(REG_COUNT));
	assign b_ok = (b_q >= 32'd1) && (b_q <= 32'(REG_COUNT));
	assign d_ok = (32'(d_q) >= 32'd1) && (32'(d_q) <= 32'(REG_COUNT));

	assign a_idx = REG_IDX_W'(a_q - 32'd1);
	assign b_idx = REG_IDX_W'(b_q - 32'd1);
	assign d_idx = REG_IDX_W'(32'(d_q) - 32'd1);
	assign rd_addr = cmd.rd_b ? b_idx : a_idx;

	assign is_and    = (mode_q == MODE_AND);
	assign is_divmod = (mode_q == MODE_DIV) || (mode_q == MODE_MOD);
	assign y_zero    = (y_q == '0);
	assign div0      = is_divmod && y_zero;

	assign sts.mode_ok   = (mode_q == MODE_SUB) || (mode_q == MODE_MUL) || is_divmod || is_and;
	assign sts.ops_ok    = is_and ? ((fv_q || a_ok) && (sv_q || b_ok) && d_ok)
	                              : (a_ok && b_ok && d_ok);
	assign sts.need_iter = (mode_q == MODE_MUL) || (is_divmod && !y_zero);
	assign sts.iter_last = (cnt_q == CNT_W'(WORD_BITS - 1));
	assign sts.out_free  = !out_vld_q || out_ready;

	// unwritten registers read as zero
	assign rd_word = rd_vld_q ? ram_rdata : '0;

	rawc_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(REG_COUNT)
	) u_regs (
		.clk  (clk),
		.we   (cmd.finish && wr_ok),
		.waddr(d_idx),
		.wdata(r),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// restoring division step
	assign rem_sh = {acc_q, sh_q[WORD_BITS-1]};
	assign diff   = rem_sh - {1'b0, y_q};

	always_comb begin
		case (mode_q)
			MODE_SUB: r = x_q - y_q;
			MODE_MUL: r = acc_q;
			MODE_DIV: r = sh_q;
			MODE_MOD: r = acc_q;
			MODE_AND: r = x_q & y_q;
			default:  r = '0;
		endcase
	end

	always_comb begin
		wr_ok    = sts.mode_ok && sts.ops_ok && !div0;
		carry_nx = sts.mode_ok ? (wr_ok && (!is_and || (r == '0))) : carry_q;
		if (!sts.mode_ok) begin
			bad_nx = BAD_NONE;
		end else if (!sts.ops_ok) begin
			bad_nx = BAD_REG;
		end else if (div0) begin
			bad_nx = BAD_DIV0;
		end else begin
			bad_nx = BAD_NONE;
		end
	end

	always_ff @(posedge clk) begin
		rd_vld_q <= vld_q[rd_addr];
		if (cmd.load) begin
			mode_q <= in_mode;
			fv_q   <= in_first_is_value;
			sv_q   <= in_second_is_value;
			a_q    <= in_first_operand;
			b_q    <= in_second_operand;
			d_q    <= in_dest_register;
		end
		if (cmd.cap_x) begin
			x_q <= (is_and && fv_q) ? WORD_BITS'(a_q) : rd_word;
		end
		if (cmd.cap_y) begin
			y_q <= (is_and && sv_q) ? WORD_BITS'(b_q) : rd_word;
		end
		if (cmd.start) begin
			acc_q <= '0;
			cnt_q <= '0;
			sh_q  <= (mode_q == MODE_MUL) ? y_q : x_q;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (mode_q == MODE_MUL) begin
				// shift-add multiply, low word only
				acc_q <= acc_q + (sh_q[0] ? x_q : '0);
				x_q   <= x_q << 1;
				sh_q  <= sh_q >> 1;
			end else if (!diff[WORD_BITS]) begin
				acc_q <= diff[WORD_BITS-1:0];
				sh_q  <= {sh_q[WORD_BITS-2:0], 1'b1};
			end else begin
				acc_q <= rem_sh[WORD_BITS-1:0];
				sh_q  <= {sh_q[WORD_BITS-2:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			out_written      <= wr_ok;
			out_result_value <= wr_ok ? OPND_W'(r) : '0;
			out_carry_flag   <= carry_nx;
			out_bad_operand  <= bad_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q   <= 1'b0;
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				carry_q   <= carry_nx;
				out_vld_q <= 1'b1;
				if (wr_ok) begin
					vld_q[d_idx] <= 1'b1;
				end
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_vld_q;

`ifndef SYNTHESIS
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("result loaded while output still held");
	a_written_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_written |-> out_bad_operand == BAD_NONE)
		else $error("write reported together with an operand error");
	a_bad_carry: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && (out_bad_operand != BAD_NONE) |-> !out_carry_flag && !carry_q)
		else $error("carry set after an operand error");
	a_iter_mode: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (mode_q == MODE_MUL) || (is_divmod && !y_zero))
		else $error("iteration without multiply or divide");
`endif

endmodule

[rtl/core/rawc_ctrl.sv]
module rawc_ctrl
	import rawc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  rawc_sts_t sts,
	output rawc_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_CAP_Y,
		ST_SETUP,
		ST_ITER,
		ST_DONE
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.rd_b   = (state_q == ST_RD_B);
		cmd.cap_x  = (state_q == ST_RD_B);
		cmd.cap_y  = (state_q == ST_CAP_Y);
		cmd.start  = (state_q == ST_SETUP);
		cmd.step   = (state_q == ST_ITER);
		cmd.finish = (state_q == ST_DONE) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RD_A;
					end
				end
				ST_RD_A: begin
					if (sts.mode_ok && sts.ops_ok) begin
						state_q <= ST_RD_B;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_RD_B: state_q <= ST_CAP_Y;
				ST_CAP_Y: state_q <= ST_SETUP;
				ST_SETUP: begin
					if (sts.need_iter) begin
						state_q <= ST_ITER;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_ITER: begin
					if (sts.iter_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/register_alu_with_carry.sv]
// register ALU with carry over a file of REG_COUNT words
// s_* carries one instruction per transaction, m_* one result per instruction
// a transaction completes on a clock edge with tvalid and tready both high
// s_tready is high only while no instruction is in progress
// the path from input transaction to m_tvalid runs through the operand reads,
// setup and a final write-back step for sub and and; mul, div and mod add one
// iteration per word bit, a zero divisor skips the iteration, and an invalid
// register or mode goes from the first read straight to the final step; a new
// instruction is taken only after the last one has finished; the shared
// shift-add / shift-subtract unit handles one bit per cycle and the single
// read port of the register RAM fetches operands in turn
// the result sits in an output register; the next instruction is accepted
// while it waits, but is held before its write-back until the result is taken
// a stalled receiver therefore holds the block in its final step and no
// result is lost or repeated
// reset clears the carry, the output valid flag and the register valid bits,
// so every register reads as zero until it is written; no clearing pass is needed
module register_alu_with_carry
	import rawc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // first_operand, second_operand, dest_register
	input  logic [4:0]  s_tuser,  // mode, first_is_value, second_is_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // written, result_value, carry_flag, bad_operand, zero pad
);

	rawc_cmd_t cmd;
	rawc_sts_t sts;

	logic              out_written;
	logic [OPND_W-1:0] out_result_value;
	logic              out_carry_flag;
	logic [BAD_W-1:0]  out_bad_operand;

	rawc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	rawc_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.in_mode           (s_tuser[2:0]),
		.in_first_is_value (s_tuser[3]),
		.in_first_operand  (s_tdata[31:0]),
		.in_second_is_value(s_tuser[4]),
		.in_second_operand (s_tdata[63:32]),
		.in_dest_register  (s_tdata[71:64]),
		.out_ready         (m_tready),
		.out_valid         (m_tvalid),
		.out_written       (out_written),
		.out_result_value  (out_result_value),
		.out_carry_flag    (out_carry_flag),
		.out_bad_operand   (out_bad_operand)
	);

	assign m_tdata = {4'd0, out_bad_operand, out_carry_flag, out_result_value, out_written};

endmodule

[bench/register_alu_with_carry_test.sv]
`timescale 1ns / 100ps

module register_alu_with_carry_test;
	import rawc_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNDEF_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_UNDEF_HI = 3'd7;
	localparam logic [OPND_W-1:0] ALL_ONES = '1;
	localparam int RESULT_HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 60;
	localparam int RUN_LIMIT_NS = 15_000_000;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              first_is_value;
		logic [OPND_W-1:0] first_operand;
		logic              second_is_value;
		logic [OPND_W-1:0] second_operand;
		logic [DEST_W-1:0] dest_register;
	} alu_instr_t;

	typedef struct packed {
		logic                 written;
		logic [WORD_BITS-1:0] result_value;
		logic                 carry_flag;
		logic [BAD_W-1:0]     bad_operand;
	} alu_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;   // first_operand, second_operand, dest_register
	logic [4:0]  s_tuser = '0;   // mode, first_is_value, second_is_value
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // written, result_value, carry_flag, bad_operand, zero pad

	logic [WORD_BITS-1:0] register_model [REG_COUNT] = '{default: '0};
	logic                 carry_model = 1'b0;
	alu_result_t          pending_results [$];
	alu_result_t          want_result;
	int                   error_count = 0;
	int                   hold_requests = 0;
	int                   hold_served = 0;
	bit                   no_stall = 1'b0;

	register_alu_with_carry uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	function automatic alu_instr_t make_instr(logic [MODE_W-1:0] mode, logic fv,
			logic [OPND_W-1:0] a, logic sv, logic [OPND_W-1:0] b, logic [DEST_W-1:0] d);
		alu_instr_t ins;
		ins.mode = mode;
		ins.first_is_value = fv;
		ins.first_operand = a;
		ins.second_is_value = sv;
		ins.second_operand = b;
		ins.dest_register = d;
		return ins;
	endfunction

	function automatic logic reg_ok(logic [OPND_W-1:0] n);
		return n >= 1 && n <= REG_COUNT;
	endfunction

	function automatic logic [WORD_BITS-1:0] reg_read(logic [OPND_W-1:0] n);
		if (!reg_ok(n))
			return '0;
		return register_model[REG_IDX_W'(n - 1)];
	endfunction

	function automatic alu_result_t execute_instruction(alu_instr_t ins);
		alu_result_t res;
		logic [WORD_BITS-1:0] x;
		logic [WORD_BITS-1:0] y;
		logic [WORD_BITS-1:0] r;
		res = '0;
		if (ins.mode <= MODE_AND) begin
			carry_model = 1'b0;
			if (ins.mode == MODE_AND) begin
				if (!((ins.first_is_value || reg_ok(ins.first_operand)) &&
						(ins.second_is_value || reg_ok(ins.second_operand)) &&
						reg_ok(ins.dest_register))) begin
					res.bad_operand = BAD_REG;
				end else begin
					x = ins.first_is_value ? ins.first_operand : reg_read(ins.first_operand);
					y = ins.second_is_value ? ins.second_operand : reg_read(ins.second_operand);
					r = x & y;
					register_model[REG_IDX_W'(ins.dest_register - 1)] = r;
					res.written = 1'b1;
					res.result_value = r;
					carry_model = (r == '0);
				end
			end else if (!reg_ok(ins.first_operand) || !reg_ok(ins.second_operand) ||
					!reg_ok(ins.dest_register)) begin
				res.bad_operand = BAD_REG;
			end else begin
				x = reg_read(ins.first_operand);
				y = reg_read(ins.second_operand);
				if ((ins.mode == MODE_DIV || ins.mode == MODE_MOD) && y == '0) begin
					res.bad_operand = BAD_DIV0;
				end else begin
					case (ins.mode)
						MODE_SUB: r = x - y;
						MODE_MUL: r = x * y;
						MODE_DIV: r = x / y;
						default:  r = x % y;
					endcase
					register_model[REG_IDX_W'(ins.dest_register - 1)] = r;
					res.written = 1'b1;
					res.result_value = r;
					carry_model = 1'b1;
				end
			end
		end
		res.carry_flag = carry_model;
		return res;
	endfunction

	task automatic check_field(string field, logic [WORD_BITS-1:0] want,
			logic [WORD_BITS-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			error_count++;
		end
	endtask

	// results are checked before the transaction of the same edge is predicted
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("result transaction with no instruction pending");
					error_count++;
				end else begin
					want_result = pending_results.pop_front();
					check_field("written", WORD_BITS'(want_result.written),
						WORD_BITS'(m_tdata[0]));
					check_field("result_value", want_result.result_value, m_tdata[32:1]);
					check_field("carry_flag", WORD_BITS'(want_result.carry_flag),
						WORD_BITS'(m_tdata[33]));
					check_field("bad_operand", WORD_BITS'(want_result.bad_operand),
						WORD_BITS'(m_tdata[35:34]));
				end
			end
			if (s_tvalid && s_tready)
				pending_results.push_back(execute_instruction(make_instr(s_tuser[2:0],
					s_tuser[3], s_tdata[31:0], s_tuser[4], s_tdata[63:32], s_tdata[71:64])));
		end
	end

	// result side back-pressure
	initial begin
		int r;
		@(posedge clk);
		forever begin
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				m_tready <= 1'b0;
				repeat (RESULT_HOLD_CYCLES) @(posedge clk);
			end else if (no_stall) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					m_tready <= 1'b1;
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end else if (r < 93) begin
					m_tready <= 1'b0;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end else begin
					m_tready <= 1'b0;
					repeat ($urandom_range(20, 80)) @(posedge clk);
				end
			end
		end
	end

	function automatic int idle_length();
		int r;
		if (no_stall)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_instruction(alu_instr_t ins);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= {ins.dest_register, ins.second_operand, ins.first_operand};
		s_tuser <= {ins.second_is_value, ins.first_is_value, ins.mode};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		gap = idle_length();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [OPND_W-1:0] random_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 20)
			return ALL_ONES;
		if (r < 35)
			return $urandom_range(0, 15);
		return $urandom;
	endfunction

	function automatic logic [OPND_W-1:0] random_register();
		int r;
		r = $urandom_range(0, 99);
		if (r < 88)
			return $urandom_range(1, REG_COUNT);
		if (r < 92)
			return '0;
		if (r < 96)
			return $urandom_range(REG_COUNT + 1, 255);
		return $urandom;
	endfunction

	function automatic alu_instr_t random_instruction();
		alu_instr_t ins;
		int r;
		r = $urandom_range(0, 99);
		if (r < 95)
			ins.mode = MODE_W'($urandom_range(MODE_SUB, MODE_AND));
		else
			ins.mode = MODE_W'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI));
		ins.first_is_value = 1'($urandom_range(0, 1));
		ins.second_is_value = 1'($urandom_range(0, 1));
		ins.first_operand = (ins.mode == MODE_AND && ins.first_is_value) ?
			random_word() : random_register();
		ins.second_operand = (ins.mode == MODE_AND && ins.second_is_value) ?
			random_word() : random_register();
		r = $urandom_range(0, 99);
		if (r < 92)
			ins.dest_register = DEST_W'($urandom_range(1, REG_COUNT));
		else if (r < 95)
			ins.dest_register = '0;
		else
			ins.dest_register = DEST_W'($urandom_range(REG_COUNT + 1, 255));
		return ins;
	endfunction

	task automatic test_directed();
		// load registers through and with literal operands
		send_instruction(make_instr(MODE_AND, 1'b1, ALL_ONES, 1'b1, ALL_ONES, 1));
		send_instruction(make_instr(MODE_AND, 1'b1, 1, 1'b1, ALL_ONES, 2));
		send_instruction(make_instr(MODE_AND, 1'b1, 0, 1'b1, ALL_ONES, 3));
		send_instruction(make_instr(MODE_AND, 1'b1, 32'hdeadbeef, 1'b1, ALL_ONES, REG_COUNT));
		send_instruction(make_instr(MODE_AND, 1'b1, 32'h80000000, 1'b1, ALL_ONES, 4));
		// wrapping arithmetic
		send_instruction(make_instr(MODE_SUB, 1'b0, 3, 1'b0, 2, 5));
		send_instruction(make_instr(MODE_SUB, 1'b0, 1, 1'b0, 1, 6));
		send_instruction(make_instr(MODE_MUL, 1'b0, 1, 1'b0, 1, 7));
		send_instruction(make_instr(MODE_MUL, 1'b0, 4, 1'b0, REG_COUNT, 8));
		send_instruction(make_instr(MODE_DIV, 1'b0, 1, 1'b0, 2, 9));
		send_instruction(make_instr(MODE_DIV, 1'b0, REG_COUNT, 1'b0, 4, 10));
		send_instruction(make_instr(MODE_MOD, 1'b0, REG_COUNT, 1'b0, 8, 11));
		// zero divisor, and register check taking precedence over it
		send_instruction(make_instr(MODE_DIV, 1'b0, 1, 1'b0, 3, 12));
		send_instruction(make_instr(MODE_MOD, 1'b0, 1, 1'b0, 3, 12));
		send_instruction(make_instr(MODE_DIV, 1'b0, 1, 1'b0, 3, 0));
		// invalid register numbers, including ones whose low byte is in range
		send_instruction(make_instr(MODE_SUB, 1'b0, 0, 1'b0, 1, 12));
		send_instruction(make_instr(MODE_SUB, 1'b0, 1, 1'b0, REG_COUNT + 1, 12));
		send_instruction(make_instr(MODE_MUL, 1'b0, 1, 1'b0, 1, 255));
		send_instruction(make_instr(MODE_SUB, 1'b0, 257, 1'b0, 1, 12));
		send_instruction(make_instr(MODE_DIV, 1'b0, ALL_ONES, 1'b0, 2, 12));
		// and with register operands and bad operands
		send_instruction(make_instr(MODE_AND, 1'b0, 1, 1'b0, REG_COUNT, 12));
		send_instruction(make_instr(MODE_AND, 1'b0, REG_COUNT, 1'b1, 0, 13));
		send_instruction(make_instr(MODE_AND, 1'b1, ALL_ONES, 1'b0, 0, 13));
		send_instruction(make_instr(MODE_AND, 1'b1, ALL_ONES, 1'b1, ALL_ONES, REG_COUNT + 1));
		// value flags are ignored outside and
		send_instruction(make_instr(MODE_SUB, 1'b1, 2, 1'b1, 2, 14));
		// undefined modes leave carry alone
		send_instruction(make_instr(MODE_UNDEF_LO, 1'b0, 1, 1'b0, 1, 15));
		send_instruction(make_instr(MODE_UNDEF_HI, 1'b1, ALL_ONES, 1'b1, ALL_ONES, 8'hff));
		send_instruction(make_instr(MODE_SUB, 1'b0, 0, 1'b0, 0, 0));
		send_instruction(make_instr(MODE_W'(MODE_UNDEF_HI - 1), 1'b0, 2, 1'b0, 3, 4));
		wait_for_results();
	endtask

	task automatic test_back_to_back();
		no_stall = 1'b1;
		repeat (40) send_instruction(random_instruction());
		no_stall = 1'b0;
		wait_for_results();
	endtask

	task automatic test_receiver_hold();
		no_stall = 1'b1;
		hold_requests++;
		repeat (20) send_instruction(random_instruction());
		no_stall = 1'b0;
		wait_for_results();
	endtask

	task automatic test_random();
		for (int i = 0; i < 570; i++) begin
			if (i % 120 == 60)
				no_stall = 1'b1;
			else if (i % 120 == 90)
				no_stall = 1'b0;
			send_instruction(random_instruction());
		end
		no_stall = 1'b0;
		wait_for_results();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_back_to_back();
		test_receiver_hold();
		test_random();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("register_alu_with_carry_test: clean");
		else
			$display("register_alu_with_carry_test: errors");
		$finish;
	end

	initial begin
		#RUN_LIMIT_NS;
		$display("register_alu_with_carry_test: errors");
		$finish;
	end

endmodule
